[rtl/core/fpa_pkg.sv]
// Shared types and codes for the fixed-partition fit allocator.
package fpa_pkg;

  // Operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } fpa_op_t;

  // Configuration register indexes
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // Fit mode codes
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } fpa_state_t;

  // Input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot_index;
    logic [15:0] size_value;
  } fpa_in_t;

  // Result word
  typedef struct packed {
    logic       granted;
    logic [3:0] granted_index;
  } fpa_out_t;

  // Broadcast controls from the controller to every cell
  typedef struct packed {
    logic       load_en;
    logic [3:0] load_slot;
    logic       free_all;
    logic       fit_mode;
    logic [4:0] block_count;
  } fpa_ctl_t;

endpackage

[rtl/core/fpa_cell.sv]
// One partition cell: holds a size and an allocated mark, refines the passing search word.
module fpa_cell import fpa_pkg::*; #(
  parameter int INDEX     = 0,
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpa_ctl_t             ctl,
  input  logic [SIZE_BITS-1:0] size_in,
  input  logic [SIZE_BITS-1:0] request,
  input  logic                 grant_set,
  input  logic [IDX_W-1:0]     grant_idx,
  input  logic                 vld_in,
  input  logic                 found_in,
  input  logic [IDX_W-1:0]     idx_in,
  input  logic [SIZE_BITS-1:0] bsize_in,
  output logic                 vld_out,
  output logic                 found_out,
  output logic [IDX_W-1:0]     idx_out,
  output logic [SIZE_BITS-1:0] bsize_out
);

  localparam logic [8:0]       CELL_NUM = 9'(INDEX);
  localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(INDEX);

  logic [SIZE_BITS-1:0] size_r;
  logic                 taken_r;
  logic                 vld_r;
  logic                 found_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SIZE_BITS-1:0] bsize_r;

  logic in_range;
  logic fits;
  logic take;
  logic load_hit;

  // Decide whether this partition beats the best seen so far
  always_comb begin
    in_range = {4'b0, ctl.block_count} > CELL_NUM;
    fits     = in_range & ~taken_r & (size_r >= request);
    take     = fits & (~found_in | ((ctl.fit_mode == FIT_BEST) & (size_r < bsize_in)));
    load_hit = ctl.load_en & ({5'b0, ctl.load_slot} == CELL_NUM);
  end

  // Hold the partition size
  always_ff @(posedge clk) begin
    if (load_hit) begin
      size_r <= size_in;
    end
  end

  // Track the allocated mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 1'b0;
    end else if (load_hit || ctl.free_all) begin
      taken_r <= 1'b0;
    end else if (grant_set && (grant_idx == CELL_IDX)) begin
      taken_r <= 1'b1;
    end
  end

  // Advance the search word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found_r <= 1'b1;
      idx_r   <= CELL_IDX;
      bsize_r <= size_r;
    end else begin
      found_r <= found_in;
      idx_r   <= idx_in;
      bsize_r <= bsize_in;
    end
  end

  assign vld_out   = vld_r;
  assign found_out = found_r;
  assign idx_out   = idx_r;
  assign bsize_out = bsize_r;

endmodule

[rtl/core/fixed_partition_fit_allocator_unit.sv]
// Top level of the fixed-partition fit allocator: controller, config and cell chain.
//
// Usage:
//   Input words (in_valid / in_stall, in_data) carry an operation: load a
//   partition size, allocate a request, or free all partitions. Every input
//   word yields exactly one result word on out_valid / out_stall, out_data.
//   For load, free-all and unused operations the result is in the output
//   register the cycle after acceptance. An allocate launches a search
//   word down a chain of NUM_SLOTS cells, one cell per cycle; the launch is
//   registered in start_r, the word passes every cell register, and its
//   result is written from the chain end into the output register while the
//   granted partition is marked at that same edge. No new input word is
//   accepted until then; other operations leave the block idle.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 sets the fit mode (0 first fit, 1 best fit), index 1 the number
//   of partitions searched. Write it only while the block is idle.
//   Reset clears all allocated marks, both config registers and the output
//   valid flag; partition sizes are unknown until loaded. While the receiver
//   stalls, the result word holds and in_stall stays high.
module fixed_partition_fit_allocator_unit import fpa_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  fpa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output fpa_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  fpa_state_t state_r, state_nxt;

  logic       fit_mode_r;
  logic [4:0] block_count_r;

  logic                 start_r;
  logic [SIZE_BITS-1:0] req_r;
  logic                 out_valid_r;
  fpa_out_t             out_data_r;

  logic                  accept;
  logic                  is_alloc;
  logic [SIZE_BITS+15:0] size_ext;
  logic [SIZE_BITS-1:0]  size_trim;
  fpa_ctl_t              ctl;
  logic                  search_done;
  logic                  grant_set;
  logic [IDX_W+3:0]      idx_ext;

  logic [NUM_SLOTS:0]   chain_vld;
  logic [NUM_SLOTS:0]   chain_found;
  logic [IDX_W-1:0]     chain_idx   [0:NUM_SLOTS];
  logic [SIZE_BITS-1:0] chain_bsize [0:NUM_SLOTS];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= FIT_FIRST;
      block_count_r <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIT_MODE:    fit_mode_r    <= cfg_data[0];
        CFG_BLOCK_COUNT: block_count_r <= cfg_data;
        default:         fit_mode_r    <= fit_mode_r;
      endcase
    end
  end

  // Trim the incoming size to the stored width
  assign size_ext  = {{SIZE_BITS{1'b0}}, in_data.size_value};
  assign size_trim = size_ext[SIZE_BITS-1:0];
  assign is_alloc  = (fpa_op_t'(in_data.operation) == OP_ALLOC);

  // Chain end and grant broadcast
  assign search_done = chain_vld[NUM_SLOTS];
  assign grant_set   = search_done & chain_found[NUM_SLOTS];
  assign idx_ext     = {{4{1'b0}}, chain_idx[NUM_SLOTS]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && is_alloc) state_nxt = ST_SEARCH;
      ST_SEARCH: if (search_done)        state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    case (state_r)
      ST_IDLE: in_stall = out_valid_r & out_stall;
      default: in_stall = 1'b1;
    endcase
    accept = in_valid & ~in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept & is_alloc;
    end
  end

  // Hold the request for the whole search
  always_ff @(posedge clk) begin
    if (accept && is_alloc) begin
      req_r <= size_trim;
    end
  end

  // Broadcast controls to the cells
  always_comb begin
    ctl.load_en     = accept & (fpa_op_t'(in_data.operation) == OP_LOAD);
    ctl.load_slot   = in_data.slot_index;
    ctl.free_all    = accept & (fpa_op_t'(in_data.operation) == OP_FREE);
    ctl.fit_mode    = fit_mode_r;
    ctl.block_count = block_count_r;
  end

  // Launch word into the first cell
  assign chain_vld[0]   = start_r;
  assign chain_found[0] = 1'b0;
  assign chain_idx[0]   = '0;
  assign chain_bsize[0] = '0;

  // Chain of partition cells
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    fpa_cell #(
      .INDEX     (i),
      .IDX_W     (IDX_W),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .size_in   (size_trim),
      .request   (req_r),
      .grant_set (grant_set),
      .grant_idx (chain_idx[NUM_SLOTS]),
      .vld_in    (chain_vld[i]),
      .found_in  (chain_found[i]),
      .idx_in    (chain_idx[i]),
      .bsize_in  (chain_bsize[i]),
      .vld_out   (chain_vld[i+1]),
      .found_out (chain_found[i+1]),
      .idx_out   (chain_idx[i+1]),
      .bsize_out (chain_bsize[i+1])
    );
  end

  // Output register: load, free-all and unused operations at accept, allocate at chain end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((accept && !is_alloc) || search_done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (search_done) begin
      out_data_r.granted       <= chain_found[NUM_SLOTS];
      out_data_r.granted_index <= chain_found[NUM_SLOTS] ? idx_ext[3:0] : 4'd0;
    end else if (accept && !is_alloc) begin
      out_data_r.granted       <= 1'b0;
      out_data_r.granted_index <= 4'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // At most one search word travels the chain
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one search word in the chain");

  // A search word only reaches the end while searching
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    search_done |-> (state_r == ST_SEARCH))
    else $error("search ended outside the search state");

  // An accepted allocate launches a search word next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_alloc) |=> (start_r && state_r == ST_SEARCH))
    else $error("allocate did not launch a search");

  // The output register is free when a search finishes
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    search_done |-> !out_valid_r)
    else $error("search result would overwrite a pending word");

  // A finished search always presents a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    search_done |=> out_valid_r)
    else $error("search result lost");

endmodule

[verif/fixed_partition_fit_allocator_unit_tb.sv]
// Self-checking testbench for the fixed-partition fit allocator: predicts every grant.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_unit_tb;
  import fpa_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int SIZE_BITS   = 16;
  localparam int RANDOM_WORDS = 500;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_CAP   = 100;

  // Partition sizes loaded by the opening words; ties and extremes on purpose
  localparam logic [15:0] SEED_SIZES [16] = '{
    16'hFFFF, 16'd0, 16'd100, 16'd50, 16'd100, 16'd200, 16'd50, 16'h8000,
    16'd300, 16'd7, 16'd50, 16'd1000, 16'h7FFF, 16'd2, 16'hFFFE, 16'd450
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  fpa_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  fpa_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_FIT_MODE;
  logic [4:0] cfg_data = '0;

  fixed_partition_fit_allocator_unit #(
    .NUM_SLOTS(NUM_SLOTS),
    .SIZE_BITS(SIZE_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words waiting to be sent, and grants expected back in order
  fpa_in_t  feed_q [$];
  fpa_out_t grant_q [$];

  // Stimulus-side copy of the loaded sizes, used to aim requests
  logic [15:0] plan_size [NUM_SLOTS];

  // Predictor state
  logic [15:0] slot_size [NUM_SLOTS];
  logic        slot_busy [NUM_SLOTS];
  logic        mode_q = FIT_FIRST;
  logic [4:0]  count_q = '0;

  int cycle_count = 0;
  int mismatch_count = 0;
  int n_load = 0, n_alloc = 0, n_grant = 0, n_free = 0, n_idle = 0, n_cfg = 0;
  int burst_left = 0, gap_left = 0;
  int stall_left = 0, stall_style = 0;
  logic in_fire = 1'b0;

  initial begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      slot_size[j] = '0;
      slot_busy[j] = 1'b0;
      plan_size[j] = '0;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Apply one accepted word to the predictor and return the grant it yields
  function automatic fpa_out_t predict_grant(fpa_in_t w);
    fpa_out_t    r;
    int          span;
    int          pick;
    bit          found;
    logic [15:0] best;
    r = '0;
    pick = 0;
    found = 1'b0;
    best = '0;
    case (w.operation)
      OP_LOAD: begin
        slot_size[w.slot_index] = w.size_value;
        slot_busy[w.slot_index] = 1'b0;
      end
      OP_ALLOC: begin
        // Counts above the table size search the whole table
        span = (int'(count_q) > NUM_SLOTS) ? NUM_SLOTS : int'(count_q);
        for (int j = 0; j < span; j++) begin
          if (!slot_busy[j] && slot_size[j] >= w.size_value) begin
            if (!found || (mode_q == FIT_BEST && slot_size[j] < best)) begin
              found = 1'b1;
              pick = j;
              best = slot_size[j];
            end
          end
        end
        if (found) begin
          slot_busy[pick] = 1'b1;
          r.granted = 1'b1;
          r.granted_index = pick[3:0];
        end
      end
      OP_FREE: begin
        for (int j = 0; j < NUM_SLOTS; j++)
          slot_busy[j] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_word(input fpa_op_t op, input logic [3:0] slot,
                           input logic [15:0] size);
    fpa_in_t w;
    w.operation = op;
    w.slot_index = slot;
    w.size_value = size;
    if (op == OP_LOAD)
      plan_size[slot] = size;
    feed_q.push_back(w);
  endtask

  // Mostly loads and aimed requests, with frees and unused codes mixed in
  task automatic queue_random_word();
    int          pick;
    int          kind;
    logic [3:0]  slot;
    logic [15:0] size;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    slot = 4'($urandom_range(0, NUM_SLOTS - 1));
    size = 16'($urandom);
    if (pick < 30) begin
      case (kind)
        0, 1, 2, 3: size = 16'($urandom_range(0, 1023));
        4, 5: size = plan_size[$urandom_range(0, NUM_SLOTS - 1)];
        8: size = 16'h0000;
        9: size = 16'hFFFF;
        default: ;
      endcase
      push_word(OP_LOAD, slot, size);
    end else if (pick < 85) begin
      case (kind)
        0, 1, 2, 3: size = plan_size[$urandom_range(0, NUM_SLOTS - 1)];
        4: size = plan_size[$urandom_range(0, NUM_SLOTS - 1)] - 16'd1;
        5: size = plan_size[$urandom_range(0, NUM_SLOTS - 1)] + 16'd1;
        6, 7: size = 16'($urandom_range(0, 255));
        9: size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: ;
      endcase
      push_word(OP_ALLOC, slot, size);
    end else if (pick < 94) begin
      push_word(OP_FREE, slot, size);
    end else begin
      push_word(OP_NONE, slot, size);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued word has gone in and every grant has come back
  task automatic drain();
    while (feed_q.size() != 0 || in_valid || grant_q.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk)
    cycle_count <= cycle_count + 1;

  // Driver: send queued words in bursts with random gaps
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        in_data <= feed_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: switch style every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((cycle_count % 6) < 2);
    endcase
  end

  // Monitor: check results, predict accepted words, track config writes
  always @(posedge clk) begin : mon
    fpa_out_t want;
    in_fire <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          flag_mismatch($sformatf("result word %0b/%0d with nothing pending",
                                  out_data.granted, out_data.granted_index));
        end else begin
          want = grant_q.pop_front();
          if (out_data.granted !== want.granted)
            flag_mismatch($sformatf("granted got %0b want %0b",
                                    out_data.granted, want.granted));
          if (out_data.granted_index !== want.granted_index)
            flag_mismatch($sformatf("granted_index got %0d want %0d",
                                    out_data.granted_index, want.granted_index));
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_grant(in_data);
        grant_q.push_back(want);
        case (in_data.operation)
          OP_LOAD: n_load++;
          OP_ALLOC: begin
            n_alloc++;
            if (want.granted) n_grant++;
          end
          OP_FREE: n_free++;
          default: n_idle++;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          CFG_FIT_MODE: mode_q = cfg_data[0];
          CFG_BLOCK_COUNT: count_q = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("watchdog expired after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stim
    int         left;
    int         n;
    int         kind;
    logic [4:0] count;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: count zero, so nothing can be granted yet
    push_word(OP_ALLOC, 4'd0, 16'd0);
    for (int j = 0; j < NUM_SLOTS; j++)
      push_word(OP_LOAD, 4'(j), SEED_SIZES[j]);
    push_word(OP_NONE, 4'hF, 16'hFFFF);
    push_word(OP_FREE, 4'h0, 16'h0000);
    drain();

    // First fit over the whole table
    write_reg(CFG_FIT_MODE, {4'b0, FIT_FIRST});
    write_reg(CFG_BLOCK_COUNT, 5'd16);
    push_word(OP_ALLOC, 4'h5, 16'd0);
    push_word(OP_ALLOC, 4'h0, 16'hFFFF);
    push_word(OP_ALLOC, 4'h0, 16'd60);
    push_word(OP_ALLOC, 4'h0, 16'd0);
    drain();

    // Best fit, ties go to the lowest index
    write_reg(CFG_FIT_MODE, {4'b0, FIT_BEST});
    push_word(OP_FREE, 4'h0, 16'd0);
    push_word(OP_ALLOC, 4'h0, 16'd50);
    push_word(OP_ALLOC, 4'h0, 16'd50);
    push_word(OP_ALLOC, 4'h0, 16'hFFFF);
    drain();

    // Count above the table size, then count zero
    write_reg(CFG_BLOCK_COUNT, 5'd31);
    repeat (80) queue_random_word();
    drain();
    write_reg(CFG_FIT_MODE, {4'b0, FIT_FIRST});
    write_reg(CFG_BLOCK_COUNT, 5'd0);
    repeat (20) queue_random_word();
    drain();

    // Random settings, random words
    left = RANDOM_WORDS - 100;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      case (kind)
        6: count = 5'd0;
        7: count = 5'd16;
        8: count = 5'($urandom_range(17, 31));
        9: count = 5'd1;
        default: count = 5'($urandom_range(1, 16));
      endcase
      write_reg(CFG_FIT_MODE, {4'b0, 1'($urandom_range(0, 1))});
      write_reg(CFG_BLOCK_COUNT, count);
      n = $urandom_range(40, 90);
      if (n > left) n = left;
      repeat (n) queue_random_word();
      left -= n;
      drain();
    end

    // Let any stray result show up
    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (grant_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", grant_q.size()));

    $display("covered %0d loads, %0d allocates (%0d granted), %0d frees, %0d unused ops",
             n_load, n_alloc, n_grant, n_free, n_idle);
    $display("across %0d register writes in both fit modes; %0d mismatches",
             n_cfg, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fpa_pkg.sv
rtl/core/fpa_cell.sv
rtl/core/fixed_partition_fit_allocator_unit.sv
verif/fixed_partition_fit_allocator_unit_tb.sv
